FILE: hdl/range_completion_watermark_core_macros.svh
// Assertion macros shared by the range completion watermark RTL.
`ifndef RANGE_COMPLETION_WATERMARK_CORE_MACROS_SVH
`define RANGE_COMPLETION_WATERMARK_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, held off during reset
`define RCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcw check failed");
// next-cycle implication, held off during reset
`define RCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcw check failed");
`else
`define RCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/rcw_pkg.sv
// Shared types and constants for the range completion watermark block.
package rcw_pkg;

  localparam int NUM_W = 31;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic [NUM_W-1:0] num_t;

  // one queued input word
  typedef struct packed {
    logic op;
    num_t lo;
    num_t hi;
    num_t qn;
  } item_t;

  typedef struct packed {
    logic [1:0] level;
  } front_stat_t;

  typedef struct packed {
    logic merging;
  } back_stat_t;

endpackage

FILE: hdl/rcw_front.sv
// Front end: accepts input words into a two-entry queue for the engine.
module rcw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  rcw_pkg::num_t       in_range_low,
  input  rcw_pkg::num_t       in_range_high,
  input  rcw_pkg::num_t       in_query_number,
  output logic                q_valid,
  output rcw_pkg::item_t      q_word,
  input  logic                q_pop,
  output rcw_pkg::front_stat_t stat
);

  rcw_pkg::item_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     level_r, level_nxt;
  logic           push;
  logic           pop;
  rcw_pkg::item_t new_word;

  assign in_stall   = (level_r == 2'd2);
  assign q_valid    = (level_r != 2'd0);
  assign q_word     = slot_r[rd_ptr_r];
  assign stat.level = level_r;

  assign push = in_valid && !in_stall;
  assign pop  = q_pop && q_valid;

  // classify: report or query; fields pass through at full width
  always_comb begin
    new_word.op = (in_operation == rcw_pkg::OP_QUERY) ? rcw_pkg::OP_QUERY
                                                       : rcw_pkg::OP_REPORT;
    new_word.lo = in_range_low;
    new_word.hi = in_range_high;
    new_word.qn = in_query_number;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 2'd1;
    end else if (pop && !push) begin
      level_nxt = level_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_word;
    end
  end

endmodule

FILE: hdl/rcw_back.sv
// Back end: done mark, pending range table and result register.
module rcw_back #(
  parameter int PENDING_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rcw_pkg::num_t       last_number,
  input  logic                q_valid,
  input  rcw_pkg::item_t      q_word,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rcw_pkg::num_t       out_done_through,
  output logic                out_all_done,
  output logic                out_query_ready,
  output logic                out_table_overflow,
  output rcw_pkg::back_stat_t stat
);

  localparam int IDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic                 state_r, state_nxt;
  rcw_pkg::num_t        mark_r, mark_nxt;
  logic [PENDING_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  rcw_pkg::num_t        slot_first_r [PENDING_SLOTS];
  rcw_pkg::num_t        slot_last_r  [PENDING_SLOTS];

  logic                 out_valid_r, out_valid_nxt;
  rcw_pkg::num_t        out_mark_r;
  logic                 out_all_r, out_ready_r, out_ovf_r;

  rcw_pkg::num_t        seek;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 has_free;
  logic [IDX_W-1:0]     free_idx;
  logic                 adjacent;
  logic                 out_free;

  logic                 emit;
  rcw_pkg::num_t        emit_mark;
  logic                 emit_ready;
  logic                 emit_ovf;
  logic                 park_we;

  assign seek     = mark_r + rcw_pkg::NUM_W'(1);
  assign adjacent = ((q_word.lo - rcw_pkg::NUM_W'(1)) == mark_r);
  assign out_free = !out_valid_r || !out_stall;

  // lowest valid slot whose first number follows the mark
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && (slot_first_r[i] == seek)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // lowest free slot
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mark_nxt       = mark_r;
    slot_valid_nxt = slot_valid_r;
    q_pop          = 1'b0;
    emit           = 1'b0;
    emit_mark      = mark_r;
    emit_ready     = 1'b0;
    emit_ovf       = 1'b0;
    park_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_word.op == rcw_pkg::OP_QUERY) begin
            if (out_free) begin
              q_pop      = 1'b1;
              emit       = 1'b1;
              emit_ready = (q_word.qn <= mark_r);
            end
          end else if (adjacent) begin
            // extend, then sweep the table for followers
            q_pop     = 1'b1;
            mark_nxt  = q_word.hi;
            state_nxt = ST_MERGE;
          end else if (out_free) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            if (has_free) begin
              park_we                  = 1'b1;
              slot_valid_nxt[free_idx] = 1'b1;
            end else begin
              emit_ovf = 1'b1;
            end
          end
        end
      end
      ST_MERGE: begin
        if (hit) begin
          mark_nxt                = slot_last_r[hit_idx];
          slot_valid_nxt[hit_idx] = 1'b0;
        end else if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mark_r       <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mark_r       <= mark_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (park_we) begin
      slot_first_r[free_idx] <= q_word.lo;
      slot_last_r[free_idx]  <= q_word.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mark_r  <= emit_mark;
      out_all_r   <= (emit_mark >= last_number);
      out_ready_r <= emit_ready;
      out_ovf_r   <= emit_ovf;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_done_through   = out_mark_r;
  assign out_all_done       = out_all_r;
  assign out_query_ready    = out_ready_r;
  assign out_table_overflow = out_ovf_r;
  assign stat.merging       = (state_r == ST_MERGE);

endmodule

FILE: hdl/range_completion_watermark_core.sv
// Top level of the range completion watermark block.
//
// Input channel (in_*): one word per handshake, taken when in_valid is high
// and in_stall is low. in_operation 0 reports a completed range
// [in_range_low, in_range_high]; 1 asks whether in_query_number is done.
// Result channel (out_*): one word per input word, in order, taken when
// out_valid is high and out_stall is low. Each word carries the done mark,
// the all-done flag against last_number, the query answer and a flag for a
// report dropped because the pending table was full.
// Config: cfg_wr_en writes cfg_wr_data into last_number; write while idle.
// Flow: a word enters a two-entry queue, then the engine. Queries and
// parked reports are handled in the idle state; a report that extends
// the mark moves it there, then the merge state absorbs parked ranges
// (one associative match per cycle, at most PENDING_SLOTS of them).
// A result is registered and appears the cycle after the engine finishes.
// Reset (rst_n low, synchronous) empties queue and table, zeroes the mark
// and last_number. A stalled result holds; the queue keeps taking words
// until it is full, then in_stall rises.
`include "range_completion_watermark_core_macros.svh"

module range_completion_watermark_core #(
  parameter int PENDING_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  rcw_pkg::num_t       cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  rcw_pkg::num_t       in_range_low,
  input  rcw_pkg::num_t       in_range_high,
  input  rcw_pkg::num_t       in_query_number,
  output logic                out_valid,
  input  logic                out_stall,
  output rcw_pkg::num_t       out_done_through,
  output logic                out_all_done,
  output logic                out_query_ready,
  output logic                out_table_overflow
);

  rcw_pkg::num_t        last_number_r, last_number_nxt;
  logic                 q_valid;
  rcw_pkg::item_t       q_word;
  logic                 q_pop;
  rcw_pkg::front_stat_t front_stat;
  rcw_pkg::back_stat_t  back_stat;

  // config register
  assign last_number_nxt = cfg_wr_en ? cfg_wr_data : last_number_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_number_r <= '0;
    end else begin
      last_number_r <= last_number_nxt;
    end
  end

  rcw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .in_query_number (in_query_number),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .q_pop           (q_pop),
    .stat            (front_stat)
  );

  rcw_back #(
    .PENDING_SLOTS (PENDING_SLOTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .last_number        (last_number_r),
    .q_valid            (q_valid),
    .q_word             (q_word),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_done_through   (out_done_through),
    .out_all_done       (out_all_done),
    .out_query_ready    (out_query_ready),
    .out_table_overflow (out_table_overflow),
    .stat               (back_stat)
  );

  // overflow only comes from reports, query answer only from queries
  `RCW_ASSERT_NOW(a_ovf_not_query, clk, rst_n, out_valid && out_table_overflow, !out_query_ready)
  // an accepted word sits in the queue on the next cycle
  `RCW_ASSERT_NEXT(a_push_lands, clk, rst_n, in_valid && !in_stall, front_stat.level != 2'd0)
  // leaving the merge sweep always loads a result
  `RCW_ASSERT_NOW(a_merge_emits, clk, rst_n, $fell(back_stat.merging) && $past(rst_n), out_valid)

endmodule

FILE: tb/tb_range_completion_watermark_core.sv
// Self-checking testbench for range_completion_watermark_core: directed and random words.
`timescale 1ns / 100ps

module tb_range_completion_watermark_core;

  localparam int            SLOTS     = 16;
  localparam rcw_pkg::num_t NUM_MAX   = '1;
  localparam int            MAX_SHOWN = 10;

  // One result word as the block should return it.
  typedef struct packed {
    rcw_pkg::num_t done_through;
    logic          all_done;
    logic          query_ready;
    logic          table_overflow;
  } status_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_wr_en;
  rcw_pkg::num_t cfg_wr_data;
  logic          in_valid;
  logic          in_stall;
  logic          in_operation;
  rcw_pkg::num_t in_range_low;
  rcw_pkg::num_t in_range_high;
  rcw_pkg::num_t in_query_number;
  logic          out_valid;
  logic          out_stall;
  rcw_pkg::num_t out_done_through;
  logic          out_all_done;
  logic          out_query_ready;
  logic          out_table_overflow;

  // Watermark tracker kept by the testbench: done mark, last_number, pending table.
  rcw_pkg::num_t wm_mark;
  rcw_pkg::num_t wm_last;
  logic          slot_busy [SLOTS];
  rcw_pkg::num_t slot_lo   [SLOTS];
  rcw_pkg::num_t slot_hi   [SLOTS];

  // Status words still owed by the block, oldest first.
  status_t expected_status [$];

  // Percent chance of a sender gap before a word / of a receiver stall run.
  int idle_pct  = 0;
  int stall_pct = 0;

  int n_words    = 0;
  int n_queries  = 0;
  int n_checked  = 0;
  int n_absorbed = 0;
  int n_dropped  = 0;
  int n_settings = 0;
  int n_errors   = 0;

  always #10 clk = ~clk;

  range_completion_watermark_core #(
    .PENDING_SLOTS(SLOTS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_range_low      (in_range_low),
    .in_range_high     (in_range_high),
    .in_query_number   (in_query_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_done_through  (out_done_through),
    .out_all_done      (out_all_done),
    .out_query_ready   (out_query_ready),
    .out_table_overflow(out_table_overflow)
  );

  // Idle length: mostly short, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 48);
  endfunction

  // Applies one accepted word to the tracker and returns the status it must produce.
  // A report that starts just past the mark (mod 2^31) moves the mark to its last
  // number, even downward, then swallows parked ranges that start right after the
  // mark, lowest slot first, at most SLOTS of them. Anything else is parked in the
  // lowest free slot, or dropped with the overflow flag when the table is full.
  function automatic status_t advance_watermark(logic op, rcw_pkg::num_t lo,
                                                rcw_pkg::num_t hi, rcw_pkg::num_t qn);
    status_t res;
    int      free_slot;
    logic    absorbed;
    res = '0;
    if (op == rcw_pkg::OP_QUERY) begin
      res.query_ready = (qn <= wm_mark);
    end else if (rcw_pkg::num_t'(lo - 1'b1) == wm_mark) begin
      wm_mark  = hi;
      absorbed = 1'b1;
      for (int n = 0; n < SLOTS && absorbed; n++) begin
        absorbed = 1'b0;
        for (int i = 0; i < SLOTS && !absorbed; i++) begin
          if (slot_busy[i] && slot_lo[i] == rcw_pkg::num_t'(wm_mark + 1'b1)) begin
            wm_mark      = slot_hi[i];
            slot_busy[i] = 1'b0;
            absorbed     = 1'b1;
            n_absorbed++;
          end
        end
      end
    end else begin
      free_slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_busy[i]) free_slot = i;
      end
      if (free_slot < 0) begin
        res.table_overflow = 1'b1;
        n_dropped++;
      end else begin
        slot_busy[free_slot] = 1'b1;
        slot_lo[free_slot]   = lo;
        slot_hi[free_slot]   = hi;
      end
    end
    res.done_through = wm_mark;
    res.all_done     = (wm_mark >= wm_last);
    return res;
  endfunction

  // Drives one word and holds it until taken; the expectation is formed at the
  // accepting edge so the tracker always reflects every word already sent.
  task automatic send_word(input logic op, input rcw_pkg::num_t lo,
                           input rcw_pkg::num_t hi, input rcw_pkg::num_t qn);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_range_low    <= lo;
    in_range_high   <= hi;
    in_query_number <= qn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_status.push_back(advance_watermark(op, lo, hi, qn));
    n_words++;
    if (op == rcw_pkg::OP_QUERY) n_queries++;
  endtask

  // Unused fields carry random bits so every input bit toggles.
  task automatic report_range(input rcw_pkg::num_t lo, input rcw_pkg::num_t hi);
    send_word(rcw_pkg::OP_REPORT, lo, hi, rcw_pkg::num_t'($urandom));
  endtask

  task automatic ask_done(input rcw_pkg::num_t qn);
    send_word(rcw_pkg::OP_QUERY, rcw_pkg::num_t'($urandom), rcw_pkg::num_t'($urandom), qn);
  endtask

  // Sender holds off until the block has returned every owed word.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic set_last_number(input rcw_pkg::num_t value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wm_last = value;
    n_settings++;
  endtask

  // Empties the pending table: each report pulls the mark to just below the lowest
  // busy slot's first number, so that slot is absorbed right away.
  task automatic drain_table();
    int i;
    i = 0;
    while (i < SLOTS) begin
      if (slot_busy[i])
        report_range(rcw_pkg::num_t'(wm_mark + 1'b1), rcw_pkg::num_t'(slot_lo[i] - 1'b1));
      else i++;
    end
  endtask

  // Hand-picked words: field extremes, both operations, each corner of the merge.
  task automatic test_directed();
    ask_done('0);                               // query at zero: ready
    ask_done(NUM_MAX);                          // query at the top: not ready
    report_range(31'd1, 31'd1);                 // extends from reset
    report_range(31'd5, 31'd9);                 // parked
    report_range(31'd3, 31'd4);                 // parked
    report_range(31'd2, 31'd2);                 // extends, chains through both -> 9
    report_range(31'd7, 31'd8);                 // stale, parked anyway
    ask_done(31'd9);
    ask_done(31'd10);
    report_range(31'd10, 31'd3);                // backward range drags mark down to 3
    report_range(31'd4, 31'd6);                 // extends, then picks up the stale 7..8
    report_range(31'd20, 31'd25);               // two slots with the same first number
    report_range(31'd20, 31'd30);
    report_range(31'd9, 31'd19);                // lower slot absorbed first -> 25
    report_range(31'd26, 31'd19);               // back to 19, now the other one -> 30
    report_range('0, 31'd5);                    // zero start, not adjacent: parked
    report_range(31'd31, NUM_MAX);              // mark hits the top, successor wraps to 0
    report_range(31'd6, NUM_MAX);
    ask_done(NUM_MAX);
    report_range('0, 31'd40);                   // zero start adjacent to a full mark
    report_range(NUM_MAX, NUM_MAX);             // far ahead: parked
    ask_done(31'd41);
  endtask

  // Fills every slot with a chain, overflows the table, then collapses the whole
  // chain with one report (longest merge).
  task automatic test_table_full();
    rcw_pkg::num_t base;
    rcw_pkg::num_t chain [SLOTS];
    rcw_pkg::num_t tmp;
    int            j;
    drain_table();
    report_range(rcw_pkg::num_t'(wm_mark + 1'b1),
                 rcw_pkg::num_t'($urandom_range(100000, 1000)));
    base = rcw_pkg::num_t'(wm_mark + 2);
    for (int i = 0; i < SLOTS; i++) chain[i] = rcw_pkg::num_t'(base + i);
    for (int i = SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = chain[i];
      chain[i] = chain[j];
      chain[j] = tmp;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if ($urandom_range(3) == 0) ask_done(chain[i]);
      report_range(chain[i], chain[i]);
    end
    wait_idle();
    report_range(31'd2, 31'd2);                 // stale and the table is full: dropped
    repeat ($urandom_range(4, 2)) report_range(rcw_pkg::num_t'($urandom_range(NUM_MAX, 2)),
                                              rcw_pkg::num_t'($urandom));
    report_range(rcw_pkg::num_t'(wm_mark + 1'b1), rcw_pkg::num_t'(wm_mark + 1'b1));
    ask_done(rcw_pkg::num_t'(base + SLOTS - 1));
    ask_done(rcw_pkg::num_t'(base + SLOTS));
  endtask

  // Each round cuts the span after the mark into pieces, shuffles them and reports
  // them, so most pieces park and get absorbed later. Queries and stray reports
  // are mixed in; now and then the mark is first thrown to a random place.
  task automatic test_shuffled_ranges(input int rounds);
    rcw_pkg::num_t piece_lo [SLOTS];
    rcw_pkg::num_t piece_hi [SLOTS];
    rcw_pkg::num_t cur;
    rcw_pkg::num_t tmp;
    int            k;
    int            j;
    int            w;
    int            busy;
    for (int r = 0; r < rounds; r++) begin
      busy = 0;
      foreach (slot_busy[i]) busy += slot_busy[i];
      if (busy > 6) drain_table();
      if ($urandom_range(4) == 0)
        report_range(rcw_pkg::num_t'(wm_mark + 1'b1), rcw_pkg::num_t'($urandom));
      k   = ($urandom_range(9) == 0) ? $urandom_range(SLOTS, 11) : $urandom_range(8, 1);
      cur = rcw_pkg::num_t'(wm_mark + 1'b1);
      for (int p = 0; p < k; p++) begin
        w           = ($urandom_range(9) == 0) ? $urandom_range(5000, 7)
                                               : $urandom_range(6, 1);
        piece_lo[p] = cur;
        piece_hi[p] = rcw_pkg::num_t'(cur + w - 1);
        cur         = rcw_pkg::num_t'(cur + w);
      end
      for (int p = k - 1; p > 0; p--) begin
        j           = $urandom_range(p);
        tmp         = piece_lo[p];
        piece_lo[p] = piece_lo[j];
        piece_lo[j] = tmp;
        tmp         = piece_hi[p];
        piece_hi[p] = piece_hi[j];
        piece_hi[j] = tmp;
      end
      for (int p = 0; p < k; p++) begin
        if ($urandom_range(9) < 3) begin
          if ($urandom_range(1)) ask_done(rcw_pkg::num_t'(wm_mark + $urandom_range(6) - 3));
          else ask_done(rcw_pkg::num_t'($urandom));
        end
        if ($urandom_range(99) < 8) begin
          if (wm_mark >= 2 && $urandom_range(1))
            report_range(rcw_pkg::num_t'($urandom_range(wm_mark, 2)),
                         rcw_pkg::num_t'($urandom));
          else
            report_range(rcw_pkg::num_t'($urandom_range(NUM_MAX, 2)),
                         rcw_pkg::num_t'($urandom));
        end
        report_range(piece_lo[p], piece_hi[p]);
      end
    end
  endtask

  // Receiver: stall runs of random length alternate with free-running stretches.
  initial begin : stall_gen
    int run_left;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        run_left = gap_len();
      end else begin
        out_stall <= 1'b0;
        run_left = $urandom_range(8, 1);
      end
    end
  end

  // Every word taken on the result side is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    status_t want;
    status_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_done_through, out_all_done, out_query_ready, out_table_overflow};
      if (expected_status.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("%0t: result word with nothing expected: mark %0d", $realtime,
                   got.done_through);
      end else begin
        want = expected_status.pop_front();
        n_checked++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display({"%0t: mismatch on result %0d: exp mark %0d all %b rdy %b ovf %b,",
                      " got mark %0d all %b rdy %b ovf %b"},
                     $realtime, n_checked, want.done_through, want.all_done,
                     want.query_ready, want.table_overflow, got.done_through,
                     got.all_done, got.query_ready, got.table_overflow);
        end
      end
    end
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int phase;
    phase = 0;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_operation    <= rcw_pkg::OP_REPORT;
    in_range_low    <= '0;
    in_range_high   <= '0;
    in_query_number <= '0;
    wm_mark = '0;
    wm_last = '0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_last_number(31'd100);
    test_directed();

    idle_pct  = 20;
    stall_pct = 20;
    set_last_number('0);
    test_table_full();

    // Random phases; each rotates the idling mix and last_number, including both
    // extremes and values near the mark so all_done flips back and forth.
    set_last_number(NUM_MAX);
    while (n_words < 720) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 20; stall_pct = 20; end
        2: begin idle_pct = 50; stall_pct = 10; end
        default: begin idle_pct = 10; stall_pct = 60; end
      endcase
      case (phase % 5)
        0: set_last_number(wm_mark);
        1: set_last_number(rcw_pkg::num_t'($urandom));
        2: set_last_number(rcw_pkg::num_t'(wm_mark + $urandom_range(40)));
        3: set_last_number('0);
        default: set_last_number(NUM_MAX);
      endcase
      test_shuffled_ranges(8);
      if (phase % 3 == 2) test_table_full();
      phase++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Summary: %0d words (%0d reports, %0d queries), %0d results checked,",
             n_words, n_words - n_queries, n_queries, n_checked);
    $display("         %0d last_number writes, %0d parked ranges merged,",
             n_settings, n_absorbed);
    $display("         %0d reports dropped on a full table, %0d mismatches",
             n_dropped, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
